### sv/fixed_point_q24_8_alu_unit_defines.svh
// Assertion macros for the Q24.8 fixed-point ALU.
// Needs clk and rst_n in the scope of each use.
`ifndef FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_Q24_8_ALU_UNIT_DEFINES_SVH

// same-cycle implication
`define FPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/fpq_pkg.sv
// Shared types and action codes for the Q24.8 fixed-point ALU.
// No dependencies.
package fpq_pkg;

  typedef logic [4:0] action_t;

  localparam action_t ACT_ADD        = 5'd0;
  localparam action_t ACT_SUB        = 5'd1;
  localparam action_t ACT_MUL        = 5'd2;
  localparam action_t ACT_DIV        = 5'd3;
  localparam action_t ACT_GT         = 5'd4;
  localparam action_t ACT_LT         = 5'd5;
  localparam action_t ACT_GE         = 5'd6;
  localparam action_t ACT_LE         = 5'd7;
  localparam action_t ACT_EQ         = 5'd8;
  localparam action_t ACT_NE         = 5'd9;
  localparam action_t ACT_MIN        = 5'd10;
  localparam action_t ACT_MAX        = 5'd11;
  localparam action_t ACT_INC        = 5'd12;
  localparam action_t ACT_DEC        = 5'd13;
  localparam action_t ACT_FROM_INT   = 5'd14;
  localparam action_t ACT_FROM_FLOAT = 5'd15;
  localparam action_t ACT_TO_INT     = 5'd16;
  localparam action_t ACT_TO_FLOAT   = 5'd17;

  localparam logic [7:0] FLT_EXP_SPECIAL = 8'hFF;
  localparam int         FLT_BIAS        = 127;
  localparam int         FLT_SHIFT_BASE  = 150;  // bias plus mantissa bits
  localparam int         FLT_MAX_RSHIFT  = 25;

  // item record carried alongside the divider
  typedef struct packed {
    logic        valid;
    action_t     act;
    logic [31:0] val;
    logic        flag;
    logic        dsign;
    logic        dzero;
  } side_t;

endpackage

### sv/fpq_if.sv
// Valid/ready channel interfaces for the Q24.8 fixed-point ALU.
// No dependencies.
interface fpq_in_if;
  logic               valid;
  logic               ready;
  logic [4:0]         action;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, action, operand_a, operand_b, input ready);
  modport sink   (input valid, action, operand_a, operand_b, output ready);
endinterface

interface fpq_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               compare_flag;
  logic               divide_error;

  modport source (output valid, result_value, compare_flag, divide_error, input ready);
  modport sink   (input valid, result_value, compare_flag, divide_error, output ready);
endinterface

### sv/fpq_div.sv
// Pipelined restoring divider, one quotient bit per stage, unsigned.
// Standalone; used by fixed_point_q24_8_alu_unit.
module fpq_div #(
  parameter int DW = 40,  // dividend and quotient width
  parameter int VW = 32   // divisor width
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic [DW-1:0] quotient_o
);

  logic [VW-1:0] rem_r [DW];
  logic [DW-1:0] z_r   [DW];  // dividend bits shifting out, quotient bits in
  logic [VW-1:0] d_r   [DW];

  for (genvar i = 0; i < DW; i++) begin : g_stage
    logic [VW-1:0] rem_in;
    logic [DW-1:0] z_in;
    logic [VW-1:0] d_in;
    logic [VW:0]   trial;
    logic          ge;
    logic [VW:0]   diff;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign z_in   = dividend_i;
      assign d_in   = divisor_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign z_in   = z_r[i-1];
      assign d_in   = d_r[i-1];
    end

    always_comb begin
      trial = {rem_in, z_in[DW-1]};
      ge    = trial >= {1'b0, d_in};
      diff  = trial - {1'b0, d_in};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[VW-1:0] : trial[VW-1:0];
        z_r[i]   <= {z_in[DW-2:0], ge};
        d_r[i]   <= d_in;
      end
    end
  end

  assign quotient_o = z_r[DW-1];

endmodule

### sv/fixed_point_q24_8_alu_unit.sv
// Channel  Dir  Handshake          Payload
// in_ch    in   valid/ready        action, operand_a, operand_b
// out_ch   out  valid/ready        result_value, compare_flag, divide_error
//
// One item per cycle while out_ch is not stalling the output register. The depth of
// each result's path is set by the divider, which resolves one quotient bit per stage.
// All actions share the same depth.
// rst_n (synchronous) clears the valid bits only.
// A full output register with out_ch.ready low freezes every stage at once.
// Depends on fpq_pkg, fpq_if.sv, fpq_div and the defines header.
`include "fixed_point_q24_8_alu_unit_defines.svh"

module fixed_point_q24_8_alu_unit #(
  parameter int FRAC_BITS  = 8,
  parameter int WORD_WIDTH = 32
) (
  input logic      clk,
  input logic      rst_n,
  fpq_in_if.sink   in_ch,
  fpq_out_if.source out_ch
);
  import fpq_pkg::*;

  localparam int W   = WORD_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int DW  = W + F;
  localparam int DLY = DW - 2;

  localparam logic [31:0] MAXW = 32'((64'd1 << (W - 1)) - 64'd1);
  localparam logic [31:0] MINW = ~MAXW;
  localparam logic [56:0] LIM  = 57'((64'd1 << (W - 1)) - 64'd1);

  function automatic logic [31:0] wrap_w(input logic [63:0] x);
    logic [W-1:0] t;
    t = x[W-1:0];
    return 32'(signed'(t));
  endfunction

  logic en;
  logic out_valid_r;
  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  // ---------------- stage A: input register
  logic        a_valid_r;
  action_t     a_act_r;
  logic [31:0] a_a_r, a_b_r, a_fb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_act_r <= in_ch.action;
      a_a_r   <= wrap_w(64'(unsigned'(in_ch.operand_a)));
      a_b_r   <= wrap_w(64'(unsigned'(in_ch.operand_b)));
      a_fb_r  <= in_ch.operand_a;
    end
  end

  // ---------------- stage 1: simple ops, multiply, operand prep
  logic signed [63:0] a64, b64;
  logic [31:0]        sval_nxt;
  logic               sflag_nxt;
  logic signed [63:0] prod_nxt;
  logic [63:0]        amag64, bmag64;
  logic               ff_sgn_nxt, ff_zero_nxt, ff_sat_nxt, ff_left_nxt;
  logic [5:0]         ff_amt_nxt;
  logic [23:0]        ff_m_nxt;
  logic [7:0]         ex;
  logic [22:0]        frac;
  logic [7:0]         ex1;
  logic signed [10:0] shf;
  logic               nan, inf;

  always_comb begin
    a64       = 64'(signed'(a_a_r));
    b64       = 64'(signed'(a_b_r));
    sval_nxt  = '0;
    sflag_nxt = 1'b0;
    case (a_act_r)
      ACT_ADD:      sval_nxt  = wrap_w(a64 + b64);
      ACT_SUB:      sval_nxt  = wrap_w(a64 - b64);
      ACT_GT:       sflag_nxt = a64 > b64;
      ACT_LT:       sflag_nxt = a64 < b64;
      ACT_GE:       sflag_nxt = a64 >= b64;
      ACT_LE:       sflag_nxt = a64 <= b64;
      ACT_EQ:       sflag_nxt = a64 == b64;
      ACT_NE:       sflag_nxt = a64 != b64;
      ACT_MIN:      sval_nxt  = (a64 < b64) ? a_a_r : a_b_r;
      ACT_MAX:      sval_nxt  = (a64 > b64) ? a_a_r : a_b_r;
      ACT_INC:      sval_nxt  = wrap_w(a64 + 64'sd1);
      ACT_DEC:      sval_nxt  = wrap_w(a64 - 64'sd1);
      ACT_FROM_INT: sval_nxt  = wrap_w(a64 <<< F);
      ACT_TO_INT:   sval_nxt  = wrap_w(a64 >>> F);
      default:      sval_nxt  = '0;
    endcase

    prod_nxt = signed'(a_a_r) * signed'(a_b_r);
    amag64   = a64[63] ? 64'(-a64) : 64'(a64);
    bmag64   = b64[63] ? 64'(-b64) : 64'(b64);

    // IEEE single decode
    ex   = a_fb_r[30:23];
    frac = a_fb_r[22:0];
    nan  = (ex == FLT_EXP_SPECIAL) && (frac != '0);
    inf  = (ex == FLT_EXP_SPECIAL) && (frac == '0);
    ex1  = (ex == 8'd0) ? 8'd1 : ex;
    ff_m_nxt = (ex == 8'd0) ? {1'b0, frac} : {1'b1, frac};
    shf  = 11'(signed'({3'b000, ex1})) - 11'(FLT_SHIFT_BASE) + 11'(F);
    ff_sgn_nxt  = a_fb_r[31];
    ff_sat_nxt  = inf || (!nan && (ff_m_nxt != '0) && (shf >= 11'(W)));
    ff_zero_nxt = nan || (ff_m_nxt == '0) || (shf < -11'(FLT_MAX_RSHIFT));
    ff_left_nxt = shf >= 11'sd0;
    ff_amt_nxt  = ff_left_nxt ? 6'(shf) : 6'(-shf);
  end

  logic               p1_valid_r;
  action_t            p1_act_r;
  logic [31:0]        p1_sval_r;
  logic               p1_sflag_r;
  logic signed [63:0] p1_prod_r;
  logic               p1_dsign_r, p1_dzero_r;
  logic [DW-1:0]      p1_dvd_r;
  logic [W-1:0]       p1_dvs_r;
  logic               p1_tf_sgn_r;
  logic [31:0]        p1_tf_mag_r;
  logic               p1_ff_sgn_r, p1_ff_zero_r, p1_ff_sat_r, p1_ff_left_r;
  logic [5:0]         p1_ff_amt_r;
  logic [23:0]        p1_ff_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else if (en) begin
      p1_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_act_r     <= a_act_r;
      p1_sval_r    <= sval_nxt;
      p1_sflag_r   <= sflag_nxt;
      p1_prod_r    <= prod_nxt;
      p1_dsign_r   <= a64[63] ^ b64[63];
      p1_dzero_r   <= (a_b_r == '0);
      p1_dvd_r     <= DW'(amag64 << F);
      p1_dvs_r     <= bmag64[W-1:0];
      p1_tf_sgn_r  <= a64[63];
      p1_tf_mag_r  <= amag64[31:0];
      p1_ff_sgn_r  <= ff_sgn_nxt;
      p1_ff_zero_r <= ff_zero_nxt;
      p1_ff_sat_r  <= ff_sat_nxt;
      p1_ff_left_r <= ff_left_nxt;
      p1_ff_amt_r  <= ff_amt_nxt;
      p1_ff_m_r    <= ff_m_nxt;
    end
  end

  // ---------------- divider, fed from stage 1
  logic [DW-1:0] quot;

  fpq_div #(.DW(DW), .VW(W)) u_div (
    .clk        (clk),
    .en         (en),
    .dividend_i (p1_dvd_r),
    .divisor_i  (p1_dvs_r),
    .quotient_o (quot)
  );

  // ---------------- stage 2: product scaling, float shifts, leading one
  logic [31:0] mulv_nxt;
  logic [55:0] ff_sh_nxt;
  logic        ff_rnd_nxt;
  logic [24:0] rtmp;
  logic [4:0]  tf_p_nxt;

  always_comb begin
    mulv_nxt = wrap_w(64'(p1_prod_r >>> F));
    rtmp     = {p1_ff_m_r, 1'b0} >> p1_ff_amt_r;
    if (p1_ff_left_r) begin
      ff_sh_nxt  = 56'(p1_ff_m_r) << p1_ff_amt_r;
      ff_rnd_nxt = 1'b0;
    end else begin
      ff_sh_nxt  = 56'(rtmp[24:1]);
      ff_rnd_nxt = rtmp[0];  // bit just below the cut: half or more rounds up
    end
    tf_p_nxt = '0;
    for (int i = 0; i < 32; i++) begin
      if (p1_tf_mag_r[i]) tf_p_nxt = 5'(i);
    end
  end

  logic        p2_valid_r;
  action_t     p2_act_r;
  logic [31:0] p2_sval_r, p2_mulv_r;
  logic        p2_sflag_r, p2_dsign_r, p2_dzero_r;
  logic        p2_tf_sgn_r;
  logic [31:0] p2_tf_mag_r;
  logic [4:0]  p2_tf_p_r;
  logic        p2_ff_sgn_r, p2_ff_zero_r, p2_ff_sat_r, p2_ff_rnd_r;
  logic [55:0] p2_ff_sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_valid_r <= 1'b0;
    end else if (en) begin
      p2_valid_r <= p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_act_r     <= p1_act_r;
      p2_sval_r    <= p1_sval_r;
      p2_mulv_r    <= mulv_nxt;
      p2_sflag_r   <= p1_sflag_r;
      p2_dsign_r   <= p1_dsign_r;
      p2_dzero_r   <= p1_dzero_r;
      p2_tf_sgn_r  <= p1_tf_sgn_r;
      p2_tf_mag_r  <= p1_tf_mag_r;
      p2_tf_p_r    <= tf_p_nxt;
      p2_ff_sgn_r  <= p1_ff_sgn_r;
      p2_ff_zero_r <= p1_ff_zero_r;
      p2_ff_sat_r  <= p1_ff_sat_r;
      p2_ff_rnd_r  <= ff_rnd_nxt;
      p2_ff_sh_r   <= ff_sh_nxt;
    end
  end

  // ---------------- stage 3: rounding, saturation, packing
  logic [56:0] ffmag;
  logic [31:0] ffv;
  logic [31:0] tnorm;
  logic [24:0] tq;
  logic        tinc;
  logic [7:0]  texp;
  logic [31:0] tfv;
  side_t       p3_nxt;

  always_comb begin
    ffmag = {1'b0, p2_ff_sh_r} + 57'(p2_ff_rnd_r);
    if (p2_ff_zero_r) begin
      ffv = '0;
    end else if (p2_ff_sat_r) begin
      ffv = p2_ff_sgn_r ? MINW : MAXW;
    end else if (!p2_ff_sgn_r) begin
      ffv = (ffmag > LIM) ? MAXW : ffmag[31:0];
    end else begin
      ffv = (ffmag > LIM + 57'd1) ? MINW : (~ffmag[31:0] + 32'd1);
    end

    // normalise to bit 31, round to nearest even on 24 bits
    tnorm = p2_tf_mag_r << (5'd31 - p2_tf_p_r);
    tinc  = tnorm[7] && ((|tnorm[6:0]) || tnorm[8]);
    tq    = {1'b0, tnorm[31:8]} + 25'(tinc);
    texp  = 8'(32'(p2_tf_p_r) + 32'(FLT_BIAS) - 32'(F) + 32'(tq[24]));
    if (p2_tf_mag_r == '0) begin
      tfv = '0;
    end else begin
      tfv = {p2_tf_sgn_r, texp, tq[24] ? 23'd0 : tq[22:0]};
    end

    p3_nxt.valid = p2_valid_r;
    p3_nxt.act   = p2_act_r;
    p3_nxt.flag  = p2_sflag_r;
    p3_nxt.dsign = p2_dsign_r;
    p3_nxt.dzero = p2_dzero_r;
    case (p2_act_r)
      ACT_MUL:        p3_nxt.val = p2_mulv_r;
      ACT_FROM_FLOAT: p3_nxt.val = ffv;
      ACT_TO_FLOAT:   p3_nxt.val = tfv;
      default:        p3_nxt.val = p2_sval_r;
    endcase
  end

  side_t p3_r;
  side_t side_r [DLY];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_r.valid <= 1'b0;
    end else if (en) begin
      p3_r <= p3_nxt;
    end
  end

  // delay line to meet the divider output
  for (genvar i = 0; i < DLY; i++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i].valid <= 1'b0;
      end else if (en) begin
        side_r[i] <= (i == 0) ? p3_r : side_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  // ---------------- output stage: divide sign fix-up
  side_t        last;
  logic [W-1:0] qw;
  logic [31:0]  val_nxt;
  logic         derr_nxt;

  always_comb begin
    last     = side_r[DLY-1];
    qw       = last.dsign ? (~quot[W-1:0] + 1'b1) : quot[W-1:0];
    val_nxt  = last.val;
    derr_nxt = 1'b0;
    if (last.act == ACT_DIV) begin
      derr_nxt = last.dzero;
      val_nxt  = last.dzero ? 32'd0 : wrap_w(64'(qw));
    end
  end

  logic [31:0] val_r;
  logic        flag_r, derr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val_r  <= val_nxt;
      flag_r <= last.flag;
      derr_r <= derr_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = val_r;
  assign out_ch.compare_flag = flag_r;
  assign out_ch.divide_error = derr_r;

  `FPQ_ASSERT_NOW(a_derr_val_zero, out_valid_r && derr_r, val_r == 32'd0, "divide error with nonzero value")
  `FPQ_ASSERT_NOW(a_flag_derr_excl, out_valid_r, !(flag_r && derr_r), "compare flag and divide error both set")
  `FPQ_ASSERT_NEXT(a_stall_freeze, !en, $stable(p3_r) && $stable(side_r[0]), "pipeline moved during stall")

endmodule
